[hw/rtl/tmvs_pkg.sv]
// ----------------------------------------------------------------------------
// tmvs_pkg
// Shared types and constants for the temporal MV select and store block.
// ----------------------------------------------------------------------------
package tmvs_pkg;

  localparam int COL_W     = 13;
  localparam int OCOL_W    = 14;
  localparam int MV_IN_W   = 16;
  localparam int MV_OUT_W  = 13;
  localparam int REF_IN_W  = 4;
  localparam int REF_OUT_W = 3;
  localparam int MASK_W    = 7;
  localparam int WID_W     = 6;
  localparam int CNT_W     = 4;   // copy index, 0..15

  // Largest component magnitude that may be saved (limit is 4096, exclusive)
  localparam logic signed [MV_IN_W-1:0] MV_MAX = 16'sd4095;
  localparam logic signed [MV_IN_W-1:0] MV_MIN = -16'sd4095;

  // Copy count saturates at 16; stored as count minus one
  localparam logic [CNT_W-1:0] LAST_COPY_MAX = 4'd15;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_TEST_SECOND,
    ST_TEST_FIRST,
    ST_EMIT
  } tmvs_state_t;

endpackage

[hw/rtl/tmvs_check.sv]
// ----------------------------------------------------------------------------
// tmvs_check
// Shared usability test for one candidate vector: positive reference,
// reference enabled in the mask, both components below the magnitude limit.
// ----------------------------------------------------------------------------
module tmvs_check
  import tmvs_pkg::*;
(
  input  logic        [MASK_W-1:0]   mask,
  input  logic signed [REF_IN_W-1:0] ref_idx,
  input  logic signed [MV_IN_W-1:0]  mv_y,
  input  logic signed [MV_IN_W-1:0]  mv_x,
  output logic                       usable
);

  logic       ref_pos;
  logic [2:0] bit_sel;
  logic       mask_hit;
  logic       small_y;
  logic       small_x;

  // ref in 1..7 here, so ref-1 fits in 3 bits and stays below 7
  assign ref_pos  = (ref_idx[REF_IN_W-1] == 1'b0) && (ref_idx != '0);
  assign bit_sel  = ref_idx[2:0] - 3'd1;
  assign mask_hit = mask[bit_sel];
  assign small_y  = (mv_y >= MV_MIN) && (mv_y <= MV_MAX);
  assign small_x  = (mv_x >= MV_MIN) && (mv_x <= MV_MAX);
  assign usable   = ref_pos && mask_hit && small_y && small_x;

endmodule

[hw/rtl/temporal_mv_select_and_store.sv]
// ----------------------------------------------------------------------------
// temporal_mv_select_and_store
// Picks the vector to save for one candidate block and writes it out once
// per covered 8x8 column.
// ----------------------------------------------------------------------------
// Usage:
//   - Input beat: all candidate fields sampled when start is high and busy
//     is low. busy stays high until the last output beat has gone out.
//   - Output beats: out_strobe marks each record for exactly one cycle;
//     the receiver cannot stall, so records come on consecutive cycles.
//     last is high on the final copy for the candidate.
//   - Timing: vector testing checks the second vector, then the first only
//     if the second fails, on one shared check unit; then one copy goes
//     out per cycle. Copies are (width_units4+1)/2 clamped to 1..16. busy
//     drops the cycle after the last beat, and the next start can be taken then.
//   - Config: ref_sign_mask_wr loads ref_sign_mask_data; write only while
//     busy is low.
//   - Reset: synchronous rst returns to idle and clears the mask.
// ----------------------------------------------------------------------------
module temporal_mv_select_and_store
  import tmvs_pkg::*;
(
  input  logic                        clk,
  input  logic                        rst,
  // configuration
  input  logic                        ref_sign_mask_wr,
  input  logic        [MASK_W-1:0]    ref_sign_mask_data,
  // input beat
  input  logic                        start,
  output logic                        busy,
  input  logic        [COL_W-1:0]     column,
  input  logic signed [MV_IN_W-1:0]   mv0_y,
  input  logic signed [MV_IN_W-1:0]   mv0_x,
  input  logic signed [MV_IN_W-1:0]   mv1_y,
  input  logic signed [MV_IN_W-1:0]   mv1_x,
  input  logic signed [REF_IN_W-1:0]  ref_first,
  input  logic signed [REF_IN_W-1:0]  ref_second,
  input  logic        [WID_W-1:0]     width_units4,
  // output beats
  output logic                        out_strobe,
  output logic        [OCOL_W-1:0]    out_column,
  output logic signed [MV_OUT_W-1:0]  saved_mv_y,
  output logic signed [MV_OUT_W-1:0]  saved_mv_x,
  output logic        [REF_OUT_W-1:0] saved_ref,
  output logic                        last
);

  tmvs_state_t state, state_next;

  logic [MASK_W-1:0] ref_mask;

  // captured candidate
  logic signed [MV_IN_W-1:0]  c0_y, c0_x, c1_y, c1_x;
  logic signed [REF_IN_W-1:0] c0_ref, c1_ref;
  logic [CNT_W-1:0]           last_idx;

  // chosen record and walk position
  logic [OCOL_W-1:0]          col;
  logic signed [MV_OUT_W-1:0] sel_y, sel_x;
  logic [REF_OUT_W-1:0]       sel_ref;
  logic [CNT_W-1:0]           copy_idx;

  // shared check unit operands
  logic signed [REF_IN_W-1:0] chk_ref;
  logic signed [MV_IN_W-1:0]  chk_y, chk_x;
  logic                       chk_ok;

  logic                       take;
  logic                       load_sel;
  logic                       clear_sel;
  logic [WID_W:0]             w_plus1;
  logic [WID_W-1:0]           half_w;
  logic [CNT_W-1:0]           last_idx_in;

  assign take = start && (state == ST_IDLE);

  // copies = (w+1)/2 clamped to 1..16; kept as copies-1
  // one extra bit on the sum so width 63 does not wrap to zero
  assign w_plus1 = {1'b0, width_units4} + 7'd1;
  assign half_w  = w_plus1[WID_W:1];
  always_comb begin
    if (half_w == '0) begin
      last_idx_in = '0;
    end else if (half_w > 6'd16) begin
      last_idx_in = LAST_COPY_MAX;
    end else begin
      last_idx_in = CNT_W'(half_w - 6'd1);
    end
  end

  // Second vector tested first; first vector on the following cycle if the second fails
  always_comb begin
    if (state == ST_TEST_FIRST) begin
      chk_ref = c0_ref;
      chk_y   = c0_y;
      chk_x   = c0_x;
    end else begin
      chk_ref = c1_ref;
      chk_y   = c1_y;
      chk_x   = c1_x;
    end
  end

  tmvs_check u_check (
    .mask    (ref_mask),
    .ref_idx (chk_ref),
    .mv_y    (chk_y),
    .mv_x    (chk_x),
    .usable  (chk_ok)
  );

  // Sequencer
  always_comb begin
    state_next = state;
    load_sel   = 1'b0;
    clear_sel  = 1'b0;
    unique case (state)
      ST_IDLE: begin
        if (start) state_next = ST_TEST_SECOND;
      end
      ST_TEST_SECOND: begin
        if (chk_ok) begin
          load_sel   = 1'b1;
          state_next = ST_EMIT;
        end else begin
          state_next = ST_TEST_FIRST;
        end
      end
      ST_TEST_FIRST: begin
        load_sel   = chk_ok;
        clear_sel  = !chk_ok;   // neither usable: zero record
        state_next = ST_EMIT;
      end
      ST_EMIT: begin
        if (copy_idx == last_idx) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      ref_mask <= '0;
    end else begin
      state <= state_next;
      if (ref_sign_mask_wr) ref_mask <= ref_sign_mask_data;
    end
  end

  // Payload: no reset needed
  always_ff @(posedge clk) begin
    if (take) begin
      c0_y     <= mv0_y;
      c0_x     <= mv0_x;
      c1_y     <= mv1_y;
      c1_x     <= mv1_x;
      c0_ref   <= ref_first;
      c1_ref   <= ref_second;
      last_idx <= last_idx_in;
      col      <= {1'b0, column};
      copy_idx <= '0;
    end else if (state == ST_EMIT) begin
      col      <= col + 14'd1;
      copy_idx <= copy_idx + 4'd1;
    end
    if (load_sel) begin
      // magnitude below 4096, so the low 13 bits keep the value
      sel_y   <= chk_y[MV_OUT_W-1:0];
      sel_x   <= chk_x[MV_OUT_W-1:0];
      sel_ref <= chk_ref[REF_OUT_W-1:0];
    end else if (clear_sel) begin
      sel_y   <= '0;
      sel_x   <= '0;
      sel_ref <= '0;
    end
  end

  assign busy       = (state != ST_IDLE);
  assign out_strobe = (state == ST_EMIT);
  assign out_column = col;
  assign saved_mv_y = sel_y;
  assign saved_mv_x = sel_x;
  assign saved_ref  = sel_ref;
  assign last       = (state == ST_EMIT) && (copy_idx == last_idx);

endmodule

[hw/rtl/tmvs_checker.sv]
// ----------------------------------------------------------------------------
// tmvs_checker
// Port-level checks for temporal_mv_select_and_store, bound to the top.
// ----------------------------------------------------------------------------
module tmvs_checker
  import tmvs_pkg::*;
(
  input logic                        clk,
  input logic                        rst,
  input logic                        busy,
  input logic                        out_strobe,
  input logic        [OCOL_W-1:0]    out_column,
  input logic signed [MV_OUT_W-1:0]  saved_mv_y,
  input logic signed [MV_OUT_W-1:0]  saved_mv_x,
  input logic        [REF_OUT_W-1:0] saved_ref,
  input logic                        last
);

  // Beats only while an item is in flight
  a_strobe_busy: assert property (@(posedge clk) disable iff (rst)
    out_strobe |-> busy)
    else $error("output beat while not busy");

  // Copies of one candidate come back to back on consecutive columns
  a_copy_walk: assert property (@(posedge clk) disable iff (rst)
    (out_strobe && !last) |=>
      (out_strobe && (out_column == $past(out_column) + 14'd1)))
    else $error("copy walk broken");

  // Every copy of one candidate carries the same record
  a_copy_same: assert property (@(posedge clk) disable iff (rst)
    (out_strobe && !last) |=>
      ($stable(saved_mv_y) && $stable(saved_mv_x) && $stable(saved_ref)))
    else $error("record changed between copies");

  // No saved reference means a zero vector
  a_zero_rec: assert property (@(posedge clk) disable iff (rst)
    (out_strobe && (saved_ref == '0)) |-> ((saved_mv_y == '0) && (saved_mv_x == '0)))
    else $error("nonzero vector with no reference");

  // Block frees up right after the final copy
  a_done: assert property (@(posedge clk) disable iff (rst)
    (out_strobe && last) |=> !busy)
    else $error("busy after last beat");

endmodule

bind temporal_mv_select_and_store tmvs_checker u_tmvs_checker (
  .clk        (clk),
  .rst        (rst),
  .busy       (busy),
  .out_strobe (out_strobe),
  .out_column (out_column),
  .saved_mv_y (saved_mv_y),
  .saved_mv_x (saved_mv_x),
  .saved_ref  (saved_ref),
  .last       (last)
);
